/* sv/edfgsd_pkg.sv */
// Shared types and constants for the EDF slot dispatcher.
// Used by the controller, the datapath and the top level.
package edfgsd_pkg;

  localparam int TASK_W = 10;
  localparam int TIME_W = 16;
  localparam int PWR_W  = 16;
  localparam int OP_W   = 2;
  localparam int OUTC_W = 3;
  localparam int LEFT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  localparam logic [OUTC_W-1:0] OUTC_INSERTED  = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_FULL      = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_SERVED    = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_IDLE      = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_RESTARTED = 3'd4;

  // One table entry; the valid flag lives in the RAM word.
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_num;
    logic [TIME_W-1:0] ready;
    logic [TIME_W-1:0] due;
    logic [PWR_W-1:0]  power;
  } edfgsd_slice_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_INS,
    ST_SCAN_TICK,
    ST_COMMIT_INS,
    ST_COMMIT_TICK
  } edfgsd_state_t;

  typedef struct packed {
    logic clr_step;      // write one zero word during the clearing pass
    logic scan_begin;    // restart the scan, capture the input payload
    logic scan_ins;      // scanning for the lowest free slot
    logic scan_tick;     // scanning for the earliest eligible deadline
    logic commit_ins;    // write the captured slice, report
    logic commit_tick;   // retire the chosen slice, report, advance time
    logic emit_full;     // report table full
    logic emit_restart;  // load time, report
  } edfgsd_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_last;
    logic clr_last;
  } edfgsd_status_t;

endpackage

/* sv/edf_granular_slot_dispatcher.sv */
// Top level of the EDF slot dispatcher.
// Depends on edfgsd_pkg, edfgsd_ctrl, edfgsd_dp (and edfgsd_ram below it).
//
// Earliest-deadline-first dispatcher for unit-length job slices. Items are
// issued with start while busy is low; each accepted item (except the unused
// op code 3) produces exactly one result, shown for a single cycle with
// out_strobe high. The result cannot be held off: capture it on that cycle.
// Insert puts the slice into the lowest free slot (or reports table full),
// tick serves the eligible slice (ready_time <= current time) with the
// smallest due_time, lowest slot on ties, and advances time by one; restart
// loads the current time. Restart and a full-table insert answer without
// a scan. Insert and tick read the whole slice table through the single
// read port of the slice RAM, one slot per cycle, before they give their
// result; busy drops again as the result appears. After reset the block
// runs a clearing pass over every word of the slice RAM with busy high
// before the first item is accepted.
module edf_granular_slot_dispatcher
  import edfgsd_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [TASK_W-1:0]   in_task_number,
  input  logic [TIME_W-1:0]   in_ready_time,
  input  logic [TIME_W-1:0]   in_due_time,
  input  logic [PWR_W-1:0]    in_power_level,
  input  logic [TIME_W-1:0]   in_new_time,
  output logic                out_strobe,
  output logic [OUTC_W-1:0]   out_outcome,
  output logic [TASK_W-1:0]   out_served_task,
  output logic [TIME_W-1:0]   out_served_ready_time,
  output logic [PWR_W-1:0]    out_served_power,
  output logic [TIME_W-1:0]   out_slot_start,
  output logic [LEFT_W-1:0]   out_entries_left
);

  edfgsd_cmd_t    cmd;
  edfgsd_status_t status;

  // sequencer: clear pass, scan, commit
  edfgsd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  // slice table, scan compare, time, count, result registers
  edfgsd_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_task_number       (in_task_number),
    .in_ready_time        (in_ready_time),
    .in_due_time          (in_due_time),
    .in_power_level       (in_power_level),
    .in_new_time          (in_new_time),
    .out_strobe           (out_strobe),
    .out_outcome          (out_outcome),
    .out_served_task      (out_served_task),
    .out_served_ready_time(out_served_ready_time),
    .out_served_power     (out_served_power),
    .out_slot_start       (out_slot_start),
    .out_entries_left     (out_entries_left)
  );

endmodule

/* sv/edfgsd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module edfgsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/edfgsd_ctrl.sv */
// Sequencing FSM for the EDF slot dispatcher.
// Depends on edfgsd_pkg; drives the datapath through edfgsd_cmd_t.
module edfgsd_ctrl
  import edfgsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OP_W-1:0]     in_op,
  input  edfgsd_status_t      status,
  output logic                busy,
  output edfgsd_cmd_t         cmd
);

  edfgsd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (in_op)
            OP_INSERT: begin
              if (status.full) begin
                cmd.emit_full = 1'b1;
              end else begin
                cmd.scan_begin = 1'b1;
                state_nxt      = ST_SCAN_INS;
              end
            end
            OP_TICK: begin
              cmd.scan_begin = 1'b1;
              state_nxt      = ST_SCAN_TICK;
            end
            OP_RESTART: begin
              cmd.emit_restart = 1'b1;
            end
            default: ;  // unused op: dropped silently
          endcase
        end
      end
      ST_SCAN_INS: begin
        cmd.scan_ins = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_COMMIT_INS;
        end
      end
      ST_SCAN_TICK: begin
        cmd.scan_tick = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_COMMIT_TICK;
        end
      end
      ST_COMMIT_INS: begin
        cmd.commit_ins = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_COMMIT_TICK: begin
        cmd.commit_tick = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/edfgsd_dp.sv */
// Datapath of the EDF slot dispatcher: slice table, scan, time and count.
// Depends on edfgsd_pkg and edfgsd_ram; controlled by edfgsd_ctrl.
module edfgsd_dp
  import edfgsd_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  edfgsd_cmd_t         cmd,
  output edfgsd_status_t      status,
  input  logic [TASK_W-1:0]   in_task_number,
  input  logic [TIME_W-1:0]   in_ready_time,
  input  logic [TIME_W-1:0]   in_due_time,
  input  logic [PWR_W-1:0]    in_power_level,
  input  logic [TIME_W-1:0]   in_new_time,
  output logic                out_strobe,
  output logic [OUTC_W-1:0]   out_outcome,
  output logic [TASK_W-1:0]   out_served_task,
  output logic [TIME_W-1:0]   out_served_ready_time,
  output logic [PWR_W-1:0]    out_served_power,
  output logic [TIME_W-1:0]   out_slot_start,
  output logic [LEFT_W-1:0]   out_entries_left
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int SL_W = $bits(edfgsd_slice_t);

  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

  // scan control
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic          issue_on_r, issue_on_nxt;
  logic          data_vld_r, data_vld_nxt;
  logic [IW-1:0] data_idx_r, data_idx_nxt;

  // best candidate so far
  logic          found_r, found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  edfgsd_slice_t best_r, best_nxt;

  // captured insert payload
  edfgsd_slice_t cap_r, cap_nxt;

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // result registers
  logic              strobe_r, strobe_nxt;
  logic [OUTC_W-1:0] outc_r, outc_nxt;
  logic [TASK_W-1:0] srv_task_r, srv_task_nxt;
  logic [TIME_W-1:0] srv_ready_r, srv_ready_nxt;
  logic [PWR_W-1:0]  srv_pwr_r, srv_pwr_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;

  // RAM ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  edfgsd_slice_t ram_wdata;
  edfgsd_slice_t ram_rdata;
  logic [SL_W-1:0] ram_rword;

  logic take;

  edfgsd_ram #(
    .WIDTH(SL_W),
    .DEPTH(ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(SL_W'(ram_wdata)),
    .re   (issue_on_r),
    .raddr(scan_idx_r),
    .rdata(ram_rword)
  );

  assign ram_rdata = edfgsd_slice_t'(ram_rword);

  always_comb begin
    // candidate test on the word read back this cycle
    take = 1'b0;
    if (data_vld_r && cmd.scan_ins) begin
      take = !ram_rdata.valid && !found_r;
    end else if (data_vld_r && cmd.scan_tick) begin
      take = ram_rdata.valid && (ram_rdata.ready <= time_r) &&
             (!found_r || (ram_rdata.due < best_r.due));
    end
  end

  always_comb begin
    scan_idx_nxt  = scan_idx_r;
    issue_on_nxt  = issue_on_r;
    data_vld_nxt  = 1'b0;
    data_idx_nxt  = data_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    cap_nxt       = cap_r;
    time_nxt      = time_r;
    count_nxt     = count_r;
    strobe_nxt    = 1'b0;
    outc_nxt      = outc_r;
    srv_task_nxt  = '0;
    srv_ready_nxt = '0;
    srv_pwr_nxt   = '0;
    start_nxt     = start_r;
    left_nxt      = left_r;
    ram_we        = 1'b0;
    ram_waddr     = best_idx_r;
    ram_wdata     = '0;

    if (cmd.clr_step) begin
      ram_we       = 1'b1;
      ram_waddr    = scan_idx_r;
      scan_idx_nxt = scan_idx_r + 1'b1;
    end

    if (cmd.scan_begin) begin
      scan_idx_nxt     = '0;
      issue_on_nxt     = 1'b1;
      found_nxt        = 1'b0;
      cap_nxt.valid    = 1'b1;
      cap_nxt.task_num = in_task_number;
      cap_nxt.ready    = in_ready_time;
      cap_nxt.due      = in_due_time;
      cap_nxt.power    = in_power_level;
    end else if (issue_on_r) begin
      data_vld_nxt = 1'b1;
      data_idx_nxt = scan_idx_r;
      scan_idx_nxt = scan_idx_r + 1'b1;
      if (scan_idx_r == LAST_IDX) begin
        issue_on_nxt = 1'b0;
      end
    end

    if (take) begin
      found_nxt    = 1'b1;
      best_idx_nxt = data_idx_r;
      best_nxt     = ram_rdata;
    end

    if (cmd.commit_ins) begin
      strobe_nxt = 1'b1;
      start_nxt  = time_r;
      if (found_r) begin
        ram_we    = 1'b1;
        ram_wdata = cap_r;
        count_nxt = count_r + 1'b1;
        outc_nxt  = OUTC_INSERTED;
      end else begin
        outc_nxt  = OUTC_FULL;
      end
      left_nxt = LEFT_W'(count_nxt);
    end

    if (cmd.commit_tick) begin
      strobe_nxt = 1'b1;
      start_nxt  = time_r;
      time_nxt   = time_r + 1'b1;
      if (found_r) begin
        ram_we        = 1'b1;   // write back with valid cleared
        count_nxt     = count_r - 1'b1;
        outc_nxt      = OUTC_SERVED;
        srv_task_nxt  = best_r.task_num;
        srv_ready_nxt = best_r.ready;
        srv_pwr_nxt   = best_r.power;
      end else begin
        outc_nxt = OUTC_IDLE;
      end
      left_nxt = LEFT_W'(count_nxt);
    end

    if (cmd.emit_full) begin
      strobe_nxt = 1'b1;
      outc_nxt   = OUTC_FULL;
      start_nxt  = time_r;
      left_nxt   = LEFT_W'(count_r);
    end

    if (cmd.emit_restart) begin
      strobe_nxt = 1'b1;
      outc_nxt   = OUTC_RESTARTED;
      time_nxt   = in_new_time;
      start_nxt  = in_new_time;
      left_nxt   = LEFT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      issue_on_r <= 1'b0;
      data_vld_r <= 1'b0;
      found_r    <= 1'b0;
      time_r     <= '0;
      count_r    <= '0;
      strobe_r   <= 1'b0;
    end else begin
      scan_idx_r <= scan_idx_nxt;
      issue_on_r <= issue_on_nxt;
      data_vld_r <= data_vld_nxt;
      found_r    <= found_nxt;
      time_r     <= time_nxt;
      count_r    <= count_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_idx_r  <= data_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
    cap_r       <= cap_nxt;
    outc_r      <= outc_nxt;
    srv_task_r  <= srv_task_nxt;
    srv_ready_r <= srv_ready_nxt;
    srv_pwr_r   <= srv_pwr_nxt;
    start_r     <= start_nxt;
    left_r      <= left_nxt;
  end

  assign status.full      = (count_r == FULL_CNT);
  assign status.scan_last = data_vld_r && (data_idx_r == LAST_IDX);
  assign status.clr_last  = (scan_idx_r == LAST_IDX);

  assign out_strobe            = strobe_r;
  assign out_outcome           = outc_r;
  assign out_served_task       = srv_task_r;
  assign out_served_ready_time = srv_ready_r;
  assign out_served_power      = srv_pwr_r;
  assign out_slot_start        = start_r;
  assign out_entries_left      = left_r;

endmodule
